FILE: hdl/ds_twr_pkg.sv
// Shared types and constants for the DS-TWR distance calculator.
package ds_twr_pkg;

  // Timestamp width, distance width and scale-factor width.
  localparam int TS_BITS    = 32;
  localparam int DIST_BITS  = 16;
  localparam int SCALE_BITS = 16;
  // The sum of four intervals needs two more bits than one interval.
  localparam int DEN_BITS   = TS_BITS + 2;
  localparam logic [SCALE_BITS-1:0] CM_PER_TICK_RESET = 16'd30739;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_ZERO_DEN   = 2'd1,
    ST_CLAMP_LOW  = 2'd2,
    ST_CLAMP_HIGH = 2'd3
  } status_t;

  // One ranging exchange.
  typedef struct packed {
    logic [TS_BITS-1:0] remote_poll_tx;
    logic [TS_BITS-1:0] remote_resp_rx;
    logic [TS_BITS-1:0] remote_final_tx;
    logic [TS_BITS-1:0] local_poll_rx;
    logic [TS_BITS-1:0] local_resp_tx;
    logic [TS_BITS-1:0] local_final_rx;
  } req_t;

  // One distance result.
  typedef struct packed {
    logic [DIST_BITS-1:0] distance_cm;
    status_t              status;
  } res_t;

  // Flags that travel alongside the quotient through the divider.
  typedef struct packed {
    logic zero_den;
    logic negative;
  } div_flags_t;

endpackage

FILE: hdl/ds_twr_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module ds_twr_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [2*ds_twr_pkg::TS_BITS-1:0]    in_num,
  input  logic [ds_twr_pkg::DEN_BITS-1:0]     in_den,
  input  ds_twr_pkg::div_flags_t              in_flags,
  output logic                                out_valid,
  output logic [ds_twr_pkg::TS_BITS-1:0]      out_quo,
  output ds_twr_pkg::div_flags_t              out_flags
);
  import ds_twr_pkg::*;

  localparam int N  = TS_BITS;
  localparam int RW = DEN_BITS + 1;

  // Stage registers; entry k holds the state after k+1 quotient bits.
  logic                v    [N];
  div_flags_t          fl   [N];
  logic [DEN_BITS-1:0] den  [N];
  logic [DEN_BITS-1:0] rem  [N];
  logic [N-1:0]        lo   [N];
  logic [N-1:0]        quo  [N];

  // The quotient is known to fit in N bits, so the upper half of the
  // numerator is already below the denominator and seeds the remainder.
  for (genvar k = 0; k < N; k++) begin : g_stage
    logic                s_v;
    div_flags_t          s_fl;
    logic [DEN_BITS-1:0] s_den;
    logic [DEN_BITS-1:0] s_rem;
    logic [N-1:0]        s_lo;
    logic [N-1:0]        s_quo;
    logic [RW-1:0]       trial;
    logic [RW-1:0]       diff;
    logic                take;

    if (k == 0) begin : g_first
      assign s_v   = in_valid;
      assign s_fl  = in_flags;
      assign s_den = in_den;
      assign s_rem = {{(DEN_BITS-N){1'b0}}, in_num[2*N-1:N]};
      assign s_lo  = in_num[N-1:0];
      assign s_quo = '0;
    end else begin : g_next
      assign s_v   = v[k-1];
      assign s_fl  = fl[k-1];
      assign s_den = den[k-1];
      assign s_rem = rem[k-1];
      assign s_lo  = lo[k-1];
      assign s_quo = quo[k-1];
    end

    // Bring down the next numerator bit and try a subtraction.
    assign trial = {s_rem, s_lo[N-1]};
    assign diff  = trial - {1'b0, s_den};
    assign take  = (trial >= {1'b0, s_den});

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= s_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        fl[k]  <= s_fl;
        den[k] <= s_den;
        rem[k] <= take ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
        lo[k]  <= {s_lo[N-2:0], 1'b0};
        quo[k] <= {s_quo[N-2:0], take};
      end
    end
  end

  assign out_valid = v[N-1];
  assign out_quo   = quo[N-1];
  assign out_flags = fl[N-1];

endmodule

FILE: hdl/ds_twr_distance_calc_top.sv
// Top level of the DS-TWR distance calculator.
//
// Usage: one request on the input channel carries the six timestamps of a
// double-sided two-way ranging exchange. A request is taken at a rising
// edge where in_valid is high and in_stall is low; a result is taken at an
// edge where out_valid is high and out_stall is low. Each request gives
// exactly one result, in order.
// The pipeline runs through interval subtraction, two 32x32 products, the
// numerator subtraction, 32 divider stages (one quotient bit each), the
// scaling multiply and the clamp/output register; the divider stages set
// the depth. Throughput is one request per cycle while nothing stalls.
// When the receiver stalls a waiting result, the whole pipeline holds and
// in_stall rises; nothing is lost or repeated.
// The user writes the scale factor through cfg_we/cfg_wdata while the
// block is idle; the block does not enforce this. Synchronous reset empties
// the pipeline and sets the scale factor to 30739 (cm per tick in Q0.16).
module ds_twr_distance_calc_top (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  ds_twr_pkg::req_t                       in_req,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output ds_twr_pkg::res_t                       out_res,
  input  logic                                   cfg_we,
  input  logic [ds_twr_pkg::SCALE_BITS-1:0]      cfg_wdata
);
  import ds_twr_pkg::*;

  localparam int PW = TS_BITS + SCALE_BITS;

  logic                  en;
  logic [SCALE_BITS-1:0] cm_per_tick;

  // Stage 1: intervals.
  logic                v1;
  logic [TS_BITS-1:0]  ra, rb, da, db;
  // Stage 2: products and denominator.
  logic                v2;
  logic [2*TS_BITS-1:0] pos, neg;
  logic [DEN_BITS-1:0] den2;
  // Stage 3: numerator magnitude and flags.
  logic                 v3;
  logic [2*TS_BITS-1:0] num3;
  logic [DEN_BITS-1:0]  den3;
  div_flags_t           fl3;
  // Divider output.
  logic                 vd;
  logic [TS_BITS-1:0]   quo;
  div_flags_t           fld;
  // Scaling stage.
  logic                 v5;
  logic [PW-1:0]        prod;
  div_flags_t           fl5;
  logic                 nz5;

  // The pipeline moves unless a finished result is held up.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Scale factor register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cm_per_tick <= CM_PER_TICK_RESET;
    end else if (cfg_we) begin
      cm_per_tick <= cfg_wdata;
    end
  end

  // Valid bits for the stages around the divider.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v5        <= vd;
      out_valid <= v5;
    end
  end

  // Modulo intervals.
  always_ff @(posedge clk) begin
    if (en) begin
      ra <= in_req.remote_resp_rx  - in_req.remote_poll_tx;
      rb <= in_req.local_final_rx  - in_req.local_resp_tx;
      da <= in_req.remote_final_tx - in_req.remote_resp_rx;
      db <= in_req.local_resp_tx   - in_req.local_poll_rx;
    end
  end

  // Cross products and the sum of intervals.
  always_ff @(posedge clk) begin
    if (en) begin
      pos  <= {{TS_BITS{1'b0}}, ra} * {{TS_BITS{1'b0}}, rb};
      neg  <= {{TS_BITS{1'b0}}, da} * {{TS_BITS{1'b0}}, db};
      den2 <= DEN_BITS'(ra) + DEN_BITS'(rb) + DEN_BITS'(da) + DEN_BITS'(db);
    end
  end

  // Magnitude of the numerator, its sign and the zero-denominator flag.
  always_ff @(posedge clk) begin
    if (en) begin
      fl3.negative <= (pos < neg);
      fl3.zero_den <= (den2 == '0);
      num3         <= (pos < neg) ? (neg - pos) : (pos - neg);
      den3         <= den2;
    end
  end

  ds_twr_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v3),
    .in_num    (num3),
    .in_den    (den3),
    .in_flags  (fl3),
    .out_valid (vd),
    .out_quo   (quo),
    .out_flags (fld)
  );

  // Scale ticks to centimetres.
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= {{SCALE_BITS{1'b0}}, quo} * {{TS_BITS{1'b0}}, cm_per_tick};
      fl5  <= fld;
      nz5  <= (quo != '0);
    end
  end

  // Clamp and status into the output register.
  always_ff @(posedge clk) begin
    if (en) begin
      if (fl5.zero_den) begin
        out_res.distance_cm <= '0;
        out_res.status      <= ST_ZERO_DEN;
      end else if (fl5.negative) begin
        out_res.distance_cm <= '0;
        out_res.status      <= nz5 ? ST_CLAMP_LOW : ST_OK;
      end else if (|prod[PW-1:SCALE_BITS+DIST_BITS]) begin
        out_res.distance_cm <= '1;
        out_res.status      <= ST_CLAMP_HIGH;
      end else begin
        out_res.distance_cm <= prod[SCALE_BITS+DIST_BITS-1:SCALE_BITS];
        out_res.status      <= ST_OK;
      end
    end
  end

endmodule

FILE: hdl/ds_twr_checker.sv
// Port-level checker for the DS-TWR distance calculator, with its bind.
module ds_twr_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_stall,
  input  logic              out_valid,
  input  logic              out_stall,
  input  ds_twr_pkg::res_t  out_res
);
  import ds_twr_pkg::*;

  // A held result stays valid and unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_res))
    else $error("stalled result changed");

  // The input is only held back by a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // Zero denominator and low clamp both report zero distance.
  a_zero_dist: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_res.status == ST_ZERO_DEN || out_res.status == ST_CLAMP_LOW)
      |-> out_res.distance_cm == '0)
    else $error("flagged result has nonzero distance");

  // High clamp reports full-scale distance.
  a_high_dist: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.status == ST_CLAMP_HIGH |-> &out_res.distance_cm)
    else $error("high clamp without full-scale distance");

endmodule

bind ds_twr_distance_calc_top ds_twr_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_res   (out_res)
);

FILE: sim/tb_ds_twr_distance_calc_top.sv
// Self-checking testbench for the DS-TWR distance calculator.
`timescale 1ns / 100ps

module tb_ds_twr_distance_calc_top;
  import ds_twr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 50;
  localparam int ITEMS_PER_PHASE = 475;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  req_t                  in_req;
  logic                  out_valid;
  logic                  out_stall;
  res_t                  out_res;
  logic                  cfg_we;
  logic [SCALE_BITS-1:0] cfg_wdata;

  // Scale factor currently held by the block, and the distances still owed.
  logic [SCALE_BITS-1:0] scale_now;
  res_t                  owed_dist[$];
  bit                    row_typed;
  res_t                  row_res;
  int                    errors;
  int                    accepted;
  int                    cycles;

  // Directed table.
  req_t                  tab_req[$];
  bit                    tab_typed[$];
  res_t                  tab_res[$];

  ds_twr_distance_calc_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Time of flight from the four intervals, scaled and clamped.
  function automatic res_t range_distance(req_t r, logic [SCALE_BITS-1:0] scale);
    logic [31:0] ra, rb, da, db;
    logic [33:0] den;
    logic [63:0] pos, neg, quot, scaled;
    res_t        res;
    ra = r.remote_resp_rx - r.remote_poll_tx;
    rb = r.local_final_rx - r.local_resp_tx;
    da = r.remote_final_tx - r.remote_resp_rx;
    db = r.local_resp_tx - r.local_poll_rx;
    den = {2'b0, ra} + {2'b0, rb} + {2'b0, da} + {2'b0, db};
    pos = {32'b0, ra} * {32'b0, rb};
    neg = {32'b0, da} * {32'b0, db};
    res.distance_cm = '0;
    res.status = ST_OK;
    if (den == 0) begin
      res.status = ST_ZERO_DEN;
    end else if (pos >= neg) begin
      quot = (pos - neg) / {30'b0, den};
      scaled = (quot * {48'b0, scale}) >> 16;
      if (scaled > 64'hFFFF) begin
        res.distance_cm = 16'hFFFF;
        res.status = ST_CLAMP_HIGH;
      end else begin
        res.distance_cm = scaled[15:0];
      end
    end else begin
      quot = (neg - pos) / {30'b0, den};
      if (quot != 0) res.status = ST_CLAMP_LOW;
    end
    return res;
  endfunction

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle counter with a hard limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("ds_twr_distance_calc_top: mismatch");
      $finish;
    end
  end

  // Record each accepted request and check each accepted result.
  always @(posedge clk) begin
    res_t want;
    if (!rst && in_valid && !in_stall) begin
      owed_dist.push_back(row_typed ? row_res : range_distance(in_req, scale_now));
      accepted <= accepted + 1;
    end
    if (!rst && out_valid && !out_stall) begin
      if (owed_dist.size() == 0) begin
        $error("unexpected result: distance_cm %0d status %0d",
               out_res.distance_cm, out_res.status);
        errors++;
      end else begin
        want = owed_dist.pop_front();
        if (out_res.distance_cm !== want.distance_cm) begin
          $error("distance_cm: expected %0d, got %0d", want.distance_cm,
                 out_res.distance_cm);
          errors++;
        end
        if (out_res.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_res.status);
          errors++;
        end
      end
    end
  end

  // Receiver stalls on its own pattern, with one long hold-off.
  initial begin
    int  mode;
    bit  held;
    bit  stall;
    held = 0;
    mode = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && accepted >= 200) begin
        held = 1;
        out_stall <= 1'b1;
        repeat (300) @(negedge clk);
      end
      if ((cycles % 64) == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: stall = 0;
        1: stall = ($urandom_range(0, 3) == 0);
        2: stall = ($urandom_range(0, 1) == 1);
        default: stall = ($urandom_range(0, 9) != 0);
      endcase
      out_stall <= stall;
    end
  end

  task automatic add_row(input req_t r, input bit typed, input logic [15:0] d,
                         input status_t st);
    res_t res;
    res.distance_cm = d;
    res.status = st;
    tab_req.push_back(r);
    tab_typed.push_back(typed);
    tab_res.push_back(res);
  endtask

  // Offer one request from a falling edge and hold it until it is taken.
  task automatic send_exchange(input req_t r, input bit typed, input res_t res);
    in_req <= r;
    in_valid <= 1'b1;
    row_typed <= typed;
    row_res <= res;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    @(negedge clk);
  endtask

  task automatic idle_for(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (owed_dist.size() != 0) @(negedge clk);
  endtask

  task automatic set_scale(input logic [SCALE_BITS-1:0] v);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    scale_now = v;
  endtask

  // Random exchange: mostly plausible ranging, some noise and extremes.
  task automatic pick_exchange(output req_t r);
    int          kind;
    logic [31:0] tof, rep_a, rep_b, base;
    kind = $urandom_range(0, 9);
    r.remote_poll_tx = $urandom;
    r.local_poll_rx = $urandom;
    if (kind <= 6) begin
      tof = $urandom_range(0, 3000);
      rep_a = $urandom_range(1, 1 << 24);
      rep_b = $urandom_range(1, 1 << 24);
      r.local_resp_tx = r.local_poll_rx + rep_b;
      r.remote_resp_rx = r.remote_poll_tx + 2 * tof + rep_b + $urandom_range(0, 200) - 100;
      r.remote_final_tx = r.remote_resp_rx + rep_a;
      r.local_final_rx = r.local_resp_tx + 2 * tof + rep_a + $urandom_range(0, 200) - 100;
    end else if (kind == 7) begin
      r.remote_resp_rx = $urandom;
      r.remote_final_tx = $urandom;
      r.local_resp_tx = $urandom;
      r.local_final_rx = $urandom;
    end else if (kind == 8) begin
      r = {6{32'hFFFF_FFFF}};
      if ($urandom_range(0, 1)) r.remote_poll_tx = '0;
      if ($urandom_range(0, 1)) r.local_resp_tx = '0;
      if ($urandom_range(0, 1)) r.local_poll_rx = $urandom;
      if ($urandom_range(0, 1)) r.remote_final_tx = '0;
    end else begin
      base = $urandom;
      r.remote_poll_tx = base;
      r.remote_resp_rx = base + $urandom_range(0, 3);
      r.remote_final_tx = r.remote_resp_rx + $urandom_range(0, 3);
      r.local_poll_rx = base;
      r.local_resp_tx = base + $urandom_range(0, 3);
      r.local_final_rx = r.local_resp_tx + $urandom_range(0, 3);
    end
  endtask

  task automatic random_phase(input int n, input bit pause_midway);
    req_t r;
    res_t none;
    int   burst;
    int   sent;
    none = '0;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 30);
      while (burst > 0 && sent < n) begin
        pick_exchange(r);
        send_exchange(r, 1'b0, none);
        burst--;
        sent++;
        if (pause_midway && sent == n / 2) wait_drained();
      end
      if ($urandom_range(0, 3) != 0) idle_for($urandom_range(0, 8));
    end
  endtask

  // Stimulus.
  initial begin
    req_t r;
    errors = 0;
    accepted = 0;
    cycles = 0;
    scale_now = CM_PER_TICK_RESET;
    rst = 1'b1;
    in_valid = 1'b0;
    in_req = '0;
    row_typed = 1'b0;
    row_res = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // All timestamps equal: zero denominator.
    add_row('0, 1'b1, 16'd0, ST_ZERO_DEN);
    // Ra = Rb = 100, no reply delay: tof 50 ticks at the reset scale.
    r = '0;
    r.remote_resp_rx = 100; r.remote_final_tx = 100; r.local_final_rx = 100;
    add_row(r, 1'b1, 16'd23, ST_OK);
    // Largest round trips wrap round zero and clamp high.
    r = '0;
    r.remote_poll_tx = 1; r.remote_final_tx = 32'hFFFF_FFFF; r.local_resp_tx = 1;
    add_row(r, 1'b1, 16'hFFFF, ST_CLAMP_HIGH);
    // Reply delays only: clearly negative flight time.
    r = '0;
    r.remote_final_tx = 1000; r.local_resp_tx = 1000; r.local_final_rx = 1000;
    add_row(r, 1'b1, 16'd0, ST_CLAMP_LOW);
    // Negative quotient that truncates to zero is not clamped.
    r = '0;
    r.remote_final_tx = 1; r.local_resp_tx = 1; r.local_final_rx = 1;
    add_row(r, 1'b1, 16'd0, ST_OK);
    // All ones and alternating patterns, checked by prediction.
    add_row({6{32'hFFFF_FFFF}}, 1'b0, 16'd0, ST_OK);
    add_row({3{64'hAAAA_AAAA_5555_5555}}, 1'b0, 16'd0, ST_OK);
    add_row({3{64'h5555_5555_AAAA_AAAA}}, 1'b0, 16'd0, ST_OK);
    for (int i = 0; i < 10; i++) begin
      pick_exchange(r);
      add_row(r, 1'b0, 16'd0, ST_OK);
    end
    for (int i = 0; i < tab_req.size(); i++) begin
      send_exchange(tab_req[i], tab_typed[i], tab_res[i]);
      if ($urandom_range(0, 2) == 0) idle_for($urandom_range(1, 3));
    end

    random_phase(ITEMS_PER_PHASE, 1'b0);
    set_scale(16'hFFFF);
    random_phase(ITEMS_PER_PHASE, 1'b1);
    set_scale(16'h0000);
    random_phase(ITEMS_PER_PHASE / 2, 1'b0);
    set_scale(16'($urandom_range(0, 65535)));
    random_phase(ITEMS_PER_PHASE, 1'b0);
    set_scale(CM_PER_TICK_RESET);
    random_phase(ITEMS_PER_PHASE / 2, 1'b0);

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && owed_dist.size() == 0) begin
      $display("ds_twr_distance_calc_top: match");
    end else begin
      $display("ds_twr_distance_calc_top: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/ds_twr_pkg.sv
hdl/ds_twr_div.sv
hdl/ds_twr_distance_calc_top.sv
hdl/ds_twr_checker.sv
sim/tb_ds_twr_distance_calc_top.sv
